@@ rtl/sher_pkg.sv @@
// ============================================================================
// Sorted hash equal-range search: shared package
// Field widths, command and register codes, controller states.
// ============================================================================
`default_nettype none

package sher_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned LAST_W  = 11;
  localparam int unsigned COUNT_W = 11;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_LO,
    ST_HI,
    ST_DONE
  } state_e;

endpackage : sher_pkg

`default_nettype wire

@@ rtl/sher_table.sv @@
// ============================================================================
// Hash table memory
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module sher_table
  import sher_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [31:0]   wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule : sher_table

`default_nettype wire

@@ rtl/sher_cfg.sv @@
// ============================================================================
// Configuration registers
// APB-style slave holding the entry count.
// ============================================================================
`default_nettype none

module sher_cfg
  import sher_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [COUNT_W-1:0]    entry_count_o
);

  logic               sel_count;
  logic [COUNT_W-1:0] entry_count_q;
  logic [COUNT_W-1:0] entry_count_d;

  assign pready    = 1'b1;
  assign sel_count = (paddr[2] == REG_ENTRY_COUNT);

  always_comb begin
    entry_count_d = entry_count_q;
    if (psel && penable && pwrite && pready && sel_count) begin
      entry_count_d = pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else begin
      entry_count_q <= entry_count_d;
    end
  end

  assign prdata        = sel_count ? APB_DATA_W'(entry_count_q) : '0;
  assign entry_count_o = entry_count_q;

endmodule : sher_cfg

`default_nettype wire

@@ rtl/sher_ctrl.sv @@
// ============================================================================
// Search controller
// Binary search then neighbour walk, one table read per cycle.
// ============================================================================
`default_nettype none

module sher_ctrl
  import sher_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH),
  parameter int unsigned CW          = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [COUNT_W-1:0]     entry_count_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tuser,
  output logic                        mem_we_o,
  output logic      [AW-1:0]          mem_waddr_o,
  output logic      [31:0]            mem_wdata_o,
  output logic      [AW-1:0]          mem_raddr_o,
  input  wire logic [31:0]            mem_rdata_i
);

  localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

  state_e state_q, state_d;

  logic [KEY_W-1:0] key_q;
  logic [CW-1:0]    first_q;
  logic [CW-1:0]    lastp1_q;
  logic [AW-1:0]    mid_q;
  logic [AW-1:0]    lo_q;
  logic [CW-1:0]    hi_q;
  logic             found_q;
  logic             m_valid_q, m_valid_d;

  logic [IDX_W-1:0] in_index;
  logic [KEY_W-1:0] in_key;
  logic             s_fire;
  logic             out_free;
  logic [CW-1:0]    n_live;

  logic             rd_eq, rd_gt;
  logic [CW:0]      sum_probe, sum_step;
  logic [AW-1:0]    mid_probe, mid_step;
  logic [CW-1:0]    f_new, l_new;
  logic             probe_ok, step_ok;
  logic [CW-1:0]    mid_inc;
  logic [AW-1:0]    lo_dec;
  logic             lo_more;
  logic [CW-1:0]    hi_start;
  logic             hi_ok;
  logic [CW-1:0]    hi_inc;
  logic             hi_more;

  assign in_index = s_axis_tdata[IDX_W-1:0];
  assign in_key   = s_axis_tdata[IDX_W+KEY_W-1:IDX_W];
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign n_live   = (32'(entry_count_i) > DEPTH_W) ? CW'(DEPTH_W) : CW'(entry_count_i);

  always_comb begin
    rd_eq     = (mem_rdata_i == key_q);
    rd_gt     = (key_q > mem_rdata_i);
    sum_probe = (CW+1)'(first_q) + (CW+1)'(lastp1_q) - (CW+1)'(1);
    mid_probe = AW'(sum_probe >> 1);
    probe_ok  = (first_q < lastp1_q);
    mid_inc   = CW'(mid_q) + CW'(1);
    f_new     = rd_gt ? mid_inc : first_q;
    l_new     = rd_gt ? lastp1_q : CW'(mid_q);
    step_ok   = (f_new < l_new);
    sum_step  = (CW+1)'(f_new) + (CW+1)'(l_new) - (CW+1)'(1);
    mid_step  = AW'(sum_step >> 1);
    lo_dec    = lo_q - AW'(1);
    lo_more   = (lo_dec != '0);
    hi_start  = (state_q == ST_CMP) ? mid_inc : hi_q;
    hi_ok     = (hi_start < n_live);
    hi_inc    = hi_q + CW'(1);
    hi_more   = (hi_inc < n_live);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && (s_axis_tuser == CMD_SEARCH)) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: state_d = probe_ok ? ST_CMP : ST_DONE;
      ST_CMP: begin
        if (rd_eq) begin
          if (mid_q != '0) begin
            state_d = ST_LO;
          end else begin
            state_d = hi_ok ? ST_HI : ST_DONE;
          end
        end else begin
          state_d = step_ok ? ST_CMP : ST_DONE;
        end
      end
      ST_LO: begin
        if (rd_eq && lo_more) begin
          state_d = ST_LO;
        end else begin
          state_d = hi_ok ? ST_HI : ST_DONE;
        end
      end
      ST_HI:   state_d = (rd_eq && hi_more) ? ST_HI : ST_DONE;
      ST_DONE: state_d = out_free ? ST_IDLE : ST_DONE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    mem_we_o      = s_fire && (s_axis_tuser == CMD_WRITE) && (32'(in_index) < DEPTH_W);
    mem_waddr_o   = AW'(in_index);
    mem_wdata_o   = in_key;
    mem_raddr_o   = mid_q;
    unique case (state_q)
      ST_PROBE: mem_raddr_o = mid_probe;
      ST_CMP: begin
        if (rd_eq) begin
          mem_raddr_o = (mid_q != '0) ? (mid_q - AW'(1)) : AW'(hi_start);
        end else begin
          mem_raddr_o = mid_step;
        end
      end
      ST_LO:   mem_raddr_o = (rd_eq && lo_more) ? (lo_dec - AW'(1)) : AW'(hi_start);
      ST_HI:   mem_raddr_o = AW'(hi_inc);
      default: mem_raddr_o = mid_q;
    endcase
    m_valid_d = m_valid_q;
    if ((state_q == ST_DONE) && out_free) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && (s_axis_tuser == CMD_SEARCH)) begin
          key_q    <= in_key;
          first_q  <= '0;
          lastp1_q <= n_live;
          found_q  <= 1'b0;
        end
      end
      ST_PROBE: mid_q <= mid_probe;
      ST_CMP: begin
        if (rd_eq) begin
          found_q <= 1'b1;
          lo_q    <= mid_q;
          hi_q    <= mid_inc;
        end else begin
          first_q  <= f_new;
          lastp1_q <= l_new;
          mid_q    <= mid_step;
        end
      end
      ST_LO: begin
        if (rd_eq) begin
          lo_q <= lo_dec;
        end
      end
      ST_HI: begin
        if (rd_eq) begin
          hi_q <= hi_inc;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_axis_tuser <= found_q;
          m_axis_tdata <= found_q ?
            {1'b0, LAST_W'(hi_q), IDX_W'(lo_q), IDX_W'(mid_q)} : '0;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;

  a_busy_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input taken while a search runs");

  a_probe_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ((CW'(mid_q) >= first_q) && (CW'(mid_q) < lastp1_q)))
    else $error("probe outside search window");

  a_lo_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LO) |-> (lo_q != '0))
    else $error("lower walk below first entry");

  a_hi_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HI) |-> (hi_q < n_live))
    else $error("upper walk past entry count");

  a_range_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && found_q) |->
      ((lo_q <= mid_q) && (CW'(mid_q) < hi_q) && (hi_q <= n_live)))
    else $error("equal range does not hold the hit");

endmodule : sher_ctrl

`default_nettype wire

@@ rtl/sorted_hash_equal_range_search.sv @@
// ============================================================================
// Sorted hash equal-range search: top level
// Table of sorted 32-bit hashes, binary search plus equal-run walk.
// ============================================================================
// Write beat: gives no result; next beat the cycle after.
// Search beat: binary-search probes (at most 11 for 1024 entries), then the
//   walk over equal neighbours plus up to two boundary reads, then the result;
//   one table read a cycle through the single read port sets the pace.
// The next beat is taken once the result register has been loaded.
// Reset: entry_count clears to zero; table entries are undefined until written.
`default_nettype none

module sorted_hash_equal_range_search
  import sher_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic      [APB_DATA_W-1:0]  prdata,
  output logic                        pready,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // entry_index[9:0], key[41:10]
  input  wire logic                   s_axis_tuser,  // cmd
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // match_index[9:0],
                                                     // range_first[19:10],
                                                     // range_last[30:20]
  output logic                        m_axis_tuser   // found
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [COUNT_W-1:0] entry_count;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [31:0]        mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [31:0]        mem_rdata;

  sher_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .entry_count_o (entry_count)
  );

  sher_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sher_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_count_i (entry_count),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

endmodule : sorted_hash_equal_range_search

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Sorted hash equal-range search: testbench
// Loads sorted hash tables of many sizes (empty, tiny, unsorted after stray
// writes) over the table stream, probes the full depth and counts above it
// with sparse tables, sets entry_count over APB between phases, and checks
// every search result against a scoreboard that repeats the binary search
// and equal-run walk on its own table copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import sher_pkg::*;

  localparam int unsigned DEPTH       = TABLE_DEPTH_DEF;
  localparam int unsigned TOTAL_ITEMS = 550;
  localparam int unsigned CALM_ITEMS  = 480;

  // Ordered so that {tuser, tdata[30:0]} maps straight onto it.
  typedef struct packed {
    logic              found;
    logic [LAST_W-1:0] range_last;
    logic [IDX_W-1:0]  range_first;
    logic [IDX_W-1:0]  match_index;
  } range_result_t;

  class range_scoreboard;
    bit [KEY_W-1:0]   hashes [DEPTH];
    bit [COUNT_W-1:0] entry_count;
    range_result_t    pending_ranges [$];
    int unsigned      errors;
    int unsigned      results;
    int unsigned      hits;

    function new();
      entry_count = '0;
      errors      = 0;
      results     = 0;
      hits        = 0;
    endfunction

    function range_result_t predict_range(bit [KEY_W-1:0] key);
      int            n;
      int            lo;
      int            hi;
      int            mid;
      int            hit;
      int            run_lo;
      int            run_hi;
      range_result_t r;
      n   = (entry_count > DEPTH) ? DEPTH : entry_count;
      lo  = 0;
      hi  = n - 1;
      hit = -1;
      r   = '0;
      while (lo <= hi && hit < 0) begin
        mid = (lo + hi) / 2;
        if (key > hashes[mid]) begin
          lo = mid + 1;
        end else if (key < hashes[mid]) begin
          hi = mid - 1;
        end else begin
          hit = mid;
        end
      end
      if (hit >= 0) begin
        run_lo = hit;
        run_hi = hit + 1;
        while (run_lo > 0 && hashes[run_lo - 1] == key) run_lo--;
        while (run_hi < n && hashes[run_hi] == key) run_hi++;
        r.found       = 1'b1;
        r.match_index = IDX_W'(hit);
        r.range_first = IDX_W'(run_lo);
        r.range_last  = LAST_W'(run_hi);
      end
      return r;
    endfunction

    function void note_beat(logic cmd, logic [IDX_W-1:0] idx, logic [KEY_W-1:0] key);
      if (cmd == CMD_WRITE) begin
        hashes[idx] = key;
      end else begin
        pending_ranges.push_back(predict_range(key));
      end
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(range_result_t got);
      range_result_t want;
      results++;
      if (got.found) hits++;
      if (pending_ranges.size() == 0) begin
        report($sformatf("result with nothing pending: found %0d match %0d range [%0d,%0d)",
                         got.found, got.match_index, got.range_first, got.range_last));
      end else begin
        want = pending_ranges.pop_front();
        if (got !== want) begin
          report($sformatf("found %0d/%0d match %0d/%0d first %0d/%0d last %0d/%0d (got/want)",
                           got.found, want.found, got.match_index, want.match_index,
                           got.range_first, want.range_first, got.range_last,
                           want.range_last));
        end
      end
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // entry_index[9:0], key[41:10]
  logic                   s_axis_tuser;   // cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // match_index[9:0], range_first[19:10],
                                          // range_last[30:20]
  logic                   m_axis_tuser;   // found

  range_scoreboard ledger;
  range_result_t   beat_seen;
  bit              calm;
  bit              tx_idle_en;
  bit              rx_idle_en;
  int unsigned     items;
  int unsigned     filled;
  int unsigned     n_searches;
  int unsigned     n_writes;
  int unsigned     n_sizes;

  sorted_hash_equal_range_search u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    stall         = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && rx_idle_en && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 15);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beat_seen = {m_axis_tuser, m_axis_tdata[30:0]};
      ledger.check_result(beat_seen);
    end
  end

  task automatic send_beat(logic cmd, logic [IDX_W-1:0] idx, logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = 0;
    if (!calm && tx_idle_en && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_TDATA_W - KEY_W - IDX_W){1'b0}}, key, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_beat(cmd, idx, key);
    if (cmd == CMD_SEARCH) n_searches++;
    else n_writes++;
    items++;
    calm = (items >= CALM_ITEMS);
  endtask

  task automatic wait_drained;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (ledger.pending_ranges.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_entry_count(logic [COUNT_W-1:0] n);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * REG_ENTRY_COUNT);
    pwdata  <= APB_DATA_W'(n);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ledger.entry_count = n;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Ascending fill with runs of equal hashes; pinned ends put zero first
  // and the all-ones hash in the last two slots.
  task automatic fill_sorted(int unsigned n, bit pin_ends);
    longint unsigned v;
    longint unsigned span;
    span = 64'hFFFF_FFFF / (n + 1);
    v    = pin_ends ? 0 : $urandom_range(0, span);
    for (int unsigned i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 2) != 0) v += $urandom_range(1, span);
      if (v > 64'hFFFF_FFFF || (pin_ends && i + 2 >= n)) v = 64'hFFFF_FFFF;
      send_beat(CMD_WRITE, IDX_W'(i), KEY_W'(v));
    end
    if (n > filled) filled = n;
  endtask

  // Sparse table: entry i holds four times i. Write only the entries that
  // the search for key will read, then search.
  task automatic search_sparse(int unsigned live, logic [KEY_W-1:0] key);
    int               lo;
    int               hi;
    int               mid;
    logic [KEY_W-1:0] probe;
    lo = 0;
    hi = int'(live) - 1;
    while (lo <= hi) begin
      mid   = (lo + hi) / 2;
      probe = KEY_W'(4 * mid);
      send_beat(CMD_WRITE, IDX_W'(mid), probe);
      if (key > probe) begin
        lo = mid + 1;
      end else if (key < probe) begin
        hi = mid - 1;
      end else begin
        if (mid > 0) send_beat(CMD_WRITE, IDX_W'(mid - 1), KEY_W'(4 * (mid - 1)));
        if (mid + 1 < int'(live)) begin
          send_beat(CMD_WRITE, IDX_W'(mid + 1), KEY_W'(4 * (mid + 1)));
        end
        lo = hi + 1;
      end
    end
    send_beat(CMD_SEARCH, IDX_W'($urandom()), key);
  endtask

  task automatic run_sparse(int unsigned live, int unsigned count);
    int unsigned      j;
    int unsigned      sel;
    logic [KEY_W-1:0] key;
    repeat (count) begin
      j   = $urandom_range(0, live - 1);
      sel = $urandom_range(0, 3);
      if (sel == 0) begin
        key = KEY_W'(4 * j + 2);
      end else if (sel == 1) begin
        key = '1;
      end else begin
        key = KEY_W'(4 * j);
      end
      search_sparse(live, key);
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key(int unsigned n);
    logic [KEY_W-1:0] k;
    int unsigned      sel;
    sel = $urandom_range(0, 9);
    if (n == 0 || sel >= 8) begin
      k = $urandom();
    end else begin
      k = ledger.hashes[$urandom_range(0, n - 1)];
      if (sel == 6) k++;
      if (sel == 7) k--;
    end
    return k;
  endfunction

  // Searches, with the odd stray write that may break the ordering.
  task automatic run_searches(int unsigned n, int unsigned count);
    repeat (count) begin
      if (filled > 0 && $urandom_range(0, 11) == 0) begin
        send_beat(CMD_WRITE, IDX_W'($urandom_range(0, filled - 1)), KEY_W'($urandom()));
      end
      send_beat(CMD_SEARCH, IDX_W'($urandom()), pick_key(n));
    end
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned sel;
    bit          refill;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_WRITE;
    calm          = 1'b0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    items         = 0;
    filled        = 0;
    n_searches    = 0;
    n_writes      = 0;
    n_sizes       = 0;
    ledger        = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table: nothing can match
    write_entry_count(0);
    send_beat(CMD_SEARCH, '0, '0);
    send_beat(CMD_SEARCH, '1, '1);
    wait_drained();

    // six entries with runs at the start and in the middle, one all-ones entry last
    write_entry_count(6);
    send_beat(CMD_WRITE, IDX_W'(0), 32'h0000_0000);
    send_beat(CMD_WRITE, IDX_W'(1), 32'h0000_0000);
    send_beat(CMD_WRITE, IDX_W'(2), 32'h0000_0005);
    send_beat(CMD_WRITE, IDX_W'(3), 32'h0000_0005);
    send_beat(CMD_WRITE, IDX_W'(4), 32'h0000_0005);
    send_beat(CMD_WRITE, IDX_W'(5), 32'hFFFF_FFFF);
    filled = 6;
    send_beat(CMD_SEARCH, '0, 32'h0000_0000);
    send_beat(CMD_SEARCH, '0, 32'h0000_0005);
    send_beat(CMD_SEARCH, '1, 32'hFFFF_FFFF);
    send_beat(CMD_SEARCH, '0, 32'h0000_0003);
    send_beat(CMD_SEARCH, '0, 32'h0000_0006);
    send_beat(CMD_SEARCH, '1, 32'hFFFF_FFFE);
    send_beat(CMD_SEARCH, '0, 32'h0000_0001);

    // full depth, then a count above the depth, on sparse tables
    wait_drained();
    write_entry_count(COUNT_W'(DEPTH));
    run_sparse(DEPTH, 6);
    wait_drained();
    write_entry_count(COUNT_W'($urandom_range(DEPTH + 1, (1 << COUNT_W) - 1)));
    run_sparse(DEPTH, 4);
    n_sizes = 4;

    while (items < TOTAL_ITEMS) begin
      sel    = $urandom_range(0, 19);
      refill = 1'b1;
      if (sel == 0) begin
        n = 0;
      end else if (sel <= 2) begin
        n      = $urandom_range(DEPTH - 24, DEPTH + 24);
        refill = 1'b0;
      end else if (sel <= 4) begin
        n = $urandom_range(49, 200);
      end else begin
        n = $urandom_range(1, 48);
      end
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      wait_drained();
      write_entry_count(COUNT_W'(n));
      if (refill) begin
        fill_sorted(n, 1'b0);
        run_searches(n, $urandom_range(4, 20));
      end else begin
        run_sparse((n > DEPTH) ? DEPTH : n, $urandom_range(2, 5));
      end
      n_sizes++;
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (ledger.pending_ranges.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("covered %0d searches (%0d results, %0d hits) and %0d table writes",
             n_searches, ledger.results, ledger.hits, n_writes);
    $display("over %0d table sizes, from empty past full depth, sorted and disturbed",
             n_sizes);
    if (ledger.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
